[rtl/lzwc_pkg.sv]
`default_nettype none

package lzwc_pkg;

  // chunk and dictionary sizing
  localparam int CHUNK_BYTES = 65536;
  // slot count is a power of two: the hash is reduced by taking its low bits
  localparam int TABLE_SLOTS = 131072;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);

  // field widths
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 17;
  localparam int FORM_W  = 2;
  localparam int EPOCH_W = 8;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

  // hashing
  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int          HASH_SHIFT = 15;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [FORM_W-1:0]    form_t;
  typedef logic [EPOCH_W-1:0]   epoch_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [OUT_LVL_W-1:0] level_t;

  localparam code_t  FIRST_CODE  = code_t'(256);
  localparam epoch_t FIRST_EPOCH = epoch_t'(1);
  localparam epoch_t LAST_EPOCH  = '1;

  // tagged variable-width forms
  localparam form_t FORM_8  = 2'd0;
  localparam form_t FORM_16 = 2'd1;
  localparam form_t FORM_24 = 2'd2;
  localparam form_t FORM_32 = 2'd3;

  // one dictionary slot; a slot is live only when its epoch matches the current one
  typedef struct packed {
    epoch_t epoch;
    code_t  prefix;
    byte_t  sym;
    code_t  code;
  } dict_entry_t;

  // dictionary write port
  typedef struct packed {
    logic        en;
    slot_t       addr;
    dict_entry_t data;
  } dict_wr_t;

  // one result item
  typedef struct packed {
    code_t code;
    form_t code_form;
    logic  chunk_end;
  } out_item_t;

  // tag class of a code
  function automatic form_t form_of(code_t c);
    form_t f;
    if ({15'd0, c} < (32'd1 << 8)) begin
      f = FORM_8;
    end else if ({15'd0, c} < (32'd1 << 16)) begin
      f = FORM_16;
    end else if ({15'd0, c} < (32'd1 << 24)) begin
      f = FORM_24;
    end else begin
      f = FORM_32;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

[rtl/lzwc_if.sv]
`default_nettype none

// raw byte stream
interface lzwc_in_if;
  logic            valid;
  logic            ready;
  lzwc_pkg::byte_t data_byte;
  logic            last_in_chunk;

  modport source (output valid, output data_byte, output last_in_chunk, input ready);
  modport sink   (input valid, input data_byte, input last_in_chunk, output ready);
endinterface

// code stream
interface lzwc_out_if;
  logic            valid;
  logic            ready;
  lzwc_pkg::code_t code;
  lzwc_pkg::form_t code_form;
  logic            chunk_end;

  modport source (output valid, output code, output code_form, output chunk_end, input ready);
  modport sink   (input valid, input code, input code_form, input chunk_end, output ready);
endinterface

`default_nettype wire

[rtl/lzwc_dict.sv]
`default_nettype none

// dictionary memory: one write and one registered read per cycle
module lzwc_dict (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire lzwc_pkg::slot_t       rd_addr,
  output lzwc_pkg::dict_entry_t      rd_data,
  input  wire lzwc_pkg::dict_wr_t    wr
);

  lzwc_pkg::dict_entry_t mem [lzwc_pkg::TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/lzwc_out_fifo.sv]
`default_nettype none

// small result queue between the compressor and the code stream
module lzwc_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire lzwc_pkg::out_item_t push_item,
  output lzwc_pkg::level_t         level,
  lzwc_out_if.source               codes
);

  lzwc_pkg::out_item_t                 slots [lzwc_pkg::OUT_DEPTH];
  logic [lzwc_pkg::OUT_PTR_W-1:0]      head;
  logic [lzwc_pkg::OUT_PTR_W-1:0]      tail;
  logic                                pop;

  assign pop             = codes.valid && codes.ready;
  assign codes.valid     = (level != '0);
  assign codes.code      = slots[head].code;
  assign codes.code_form = slots[head].code_form;
  assign codes.chunk_end = slots[head].chunk_end;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/lzw_chunk_compressor_unit.sv]
`default_nettype none

// LZW compressor for chunks of up to 65536 bytes, one byte per transfer on raw_bytes, codes
// with their tag form on codes. The first byte of a chunk opens the match, and is emitted at
// once if it ends the chunk; every later byte goes through hash multiply, hash fold and slot
// read, and compare, plus a slot read per extra linear probe of the dictionary memory, and
// a closing step when the byte ends the chunk. As the memory read is registered, the probe
// loop checks one slot a cycle. Chunks are told apart by an 8-bit epoch in each slot, so
// ending a chunk costs nothing; after reset, and after every 255th chunk, a clearing pass
// sweeps all 131072 dictionary slots and no byte is taken meanwhile. Results wait in a
// 4-entry queue, so a stalled code stream holds up input only once that queue is nearly full.
module lzw_chunk_compressor_unit (
  input  wire logic clk,
  input  wire logic rst,
  lzwc_in_if.sink   raw_bytes,
  lzwc_out_if.source codes
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_HASH   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  state_t                 state, state_next;
  lzwc_pkg::byte_t        cur_byte, cur_byte_next;
  logic                   item_end, item_end_next;
  lzwc_pkg::code_t        match_code, match_code_next;
  logic                   match_active, match_active_next;
  lzwc_pkg::code_t        next_free_code, next_free_code_next;
  lzwc_pkg::count_t       bytes_in_chunk, bytes_in_chunk_next;
  lzwc_pkg::epoch_t       epoch, epoch_next;
  logic [31:0]            hash_prod, hash_prod_next;
  lzwc_pkg::slot_t        probe_idx, probe_idx_next;
  lzwc_pkg::slot_t        probe_cnt, probe_cnt_next;
  lzwc_pkg::slot_t        clr_idx, clr_idx_next;

  logic                   take;
  lzwc_pkg::count_t       bytes_inc;
  logic                   byte_ends;
  logic [31:0]            hash_fold;
  lzwc_pkg::slot_t        start_slot;
  lzwc_pkg::slot_t        probe_succ;
  logic                   entry_live;
  logic                   key_hit;
  logic                   close_chunk;

  logic                   rd_en;
  lzwc_pkg::slot_t        rd_addr;
  lzwc_pkg::dict_entry_t  rd_data;
  lzwc_pkg::dict_wr_t     dict_wr;

  logic                   push;
  lzwc_pkg::out_item_t    push_item;
  lzwc_pkg::code_t        push_code;
  logic                   push_end;
  lzwc_pkg::level_t       level;

  // input handshake: room for two results before a byte is taken
  assign raw_bytes.ready = (state == ST_IDLE) &&
                           (level <= lzwc_pkg::level_t'(lzwc_pkg::OUT_DEPTH - 2));
  assign take            = raw_bytes.valid && raw_bytes.ready;

  // chunk length limit
  assign bytes_inc = bytes_in_chunk + 1'b1;
  assign byte_ends = raw_bytes.last_in_chunk ||
                     (bytes_inc >= lzwc_pkg::count_t'(lzwc_pkg::CHUNK_BYTES));

  // hash fold and probe addressing
  assign hash_fold  = hash_prod ^ (hash_prod >> lzwc_pkg::HASH_SHIFT);
  assign start_slot = hash_fold[lzwc_pkg::SLOT_W-1:0];
  assign probe_succ = (probe_idx == lzwc_pkg::slot_t'(lzwc_pkg::TABLE_SLOTS - 1)) ?
                      '0 : probe_idx + 1'b1;

  // slot compare
  assign entry_live = (rd_data.epoch == epoch);
  assign key_hit    = (rd_data.prefix == match_code) && (rd_data.sym == cur_byte);

  // next-state logic
  always_comb begin
    state_next          = state;
    cur_byte_next       = cur_byte;
    item_end_next       = item_end;
    match_code_next     = match_code;
    match_active_next   = match_active;
    next_free_code_next = next_free_code;
    bytes_in_chunk_next = bytes_in_chunk;
    epoch_next          = epoch;
    hash_prod_next      = hash_prod;
    probe_idx_next      = probe_idx;
    probe_cnt_next      = probe_cnt;
    clr_idx_next        = clr_idx;
    rd_en               = 1'b0;
    rd_addr             = start_slot;
    dict_wr             = '0;
    push                = 1'b0;
    push_code           = match_code;
    push_end            = 1'b0;
    close_chunk         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (take) begin
          cur_byte_next       = raw_bytes.data_byte;
          item_end_next       = byte_ends;
          bytes_in_chunk_next = bytes_inc;
          if (!match_active) begin
            // first byte of a chunk opens the match
            match_code_next   = lzwc_pkg::code_t'(raw_bytes.data_byte);
            match_active_next = 1'b1;
            if (byte_ends) begin
              push        = 1'b1;
              push_code   = lzwc_pkg::code_t'(raw_bytes.data_byte);
              push_end    = 1'b1;
              close_chunk = 1'b1;
            end
          end else begin
            state_next = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        hash_prod_next = 32'({match_code, cur_byte}) * lzwc_pkg::HASH_MULT;
        state_next     = ST_READ;
      end

      ST_READ: begin
        rd_en          = 1'b1;
        rd_addr        = start_slot;
        probe_idx_next = start_slot;
        probe_cnt_next = '0;
        state_next     = ST_CHECK;
      end

      ST_CHECK: begin
        if (!entry_live) begin
          // miss: emit the match and claim this empty slot
          push                   = 1'b1;
          push_code              = match_code;
          dict_wr.en             = 1'b1;
          dict_wr.addr           = probe_idx;
          dict_wr.data.epoch     = epoch;
          dict_wr.data.prefix    = match_code;
          dict_wr.data.sym       = cur_byte;
          dict_wr.data.code      = next_free_code;
          next_free_code_next    = next_free_code + 1'b1;
          match_code_next        = lzwc_pkg::code_t'(cur_byte);
          state_next             = item_end ? ST_FINISH : ST_IDLE;
        end else if (key_hit) begin
          match_code_next = rd_data.code;
          state_next      = item_end ? ST_FINISH : ST_IDLE;
        end else if (probe_cnt == lzwc_pkg::slot_t'(lzwc_pkg::TABLE_SLOTS - 1)) begin
          // table full: emit, skip the insertion, keep numbering
          push                = 1'b1;
          push_code           = match_code;
          next_free_code_next = next_free_code + 1'b1;
          match_code_next     = lzwc_pkg::code_t'(cur_byte);
          state_next          = item_end ? ST_FINISH : ST_IDLE;
        end else begin
          // occupied by another pair: next slot
          rd_en          = 1'b1;
          rd_addr        = probe_succ;
          probe_idx_next = probe_succ;
          probe_cnt_next = probe_cnt + 1'b1;
        end
      end

      ST_FINISH: begin
        push        = 1'b1;
        push_code   = match_code;
        push_end    = 1'b1;
        close_chunk = 1'b1;
      end

      ST_CLEAR: begin
        dict_wr.en   = 1'b1;
        dict_wr.addr = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == lzwc_pkg::slot_t'(lzwc_pkg::TABLE_SLOTS - 1)) begin
          epoch_next = lzwc_pkg::FIRST_EPOCH;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // end of chunk: fresh dictionary by epoch, or a sweep once epochs run out
    if (close_chunk) begin
      match_code_next     = '0;
      match_active_next   = 1'b0;
      next_free_code_next = lzwc_pkg::FIRST_CODE;
      bytes_in_chunk_next = '0;
      if (epoch == lzwc_pkg::LAST_EPOCH) begin
        clr_idx_next = '0;
        state_next   = ST_CLEAR;
      end else begin
        epoch_next = epoch + 1'b1;
        state_next = ST_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      match_code     <= '0;
      match_active   <= 1'b0;
      next_free_code <= lzwc_pkg::FIRST_CODE;
      bytes_in_chunk <= '0;
      epoch          <= '0;
      clr_idx        <= '0;
    end else begin
      state          <= state_next;
      match_code     <= match_code_next;
      match_active   <= match_active_next;
      next_free_code <= next_free_code_next;
      bytes_in_chunk <= bytes_in_chunk_next;
      epoch          <= epoch_next;
      clr_idx        <= clr_idx_next;
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    cur_byte  <= cur_byte_next;
    item_end  <= item_end_next;
    hash_prod <= hash_prod_next;
    probe_idx <= probe_idx_next;
    probe_cnt <= probe_cnt_next;
  end

  // result item
  always_comb begin
    push_item.code      = push_code;
    push_item.code_form = lzwc_pkg::form_of(push_code);
    push_item.chunk_end = push_end;
  end

  lzwc_dict u_dict (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (dict_wr)
  );

  lzwc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .level     (level),
    .codes     (codes)
  );

  // dictionary is written only by an insertion or the clearing sweep
  assert property (@(posedge clk) disable iff (rst)
    dict_wr.en |-> (state == ST_CHECK || state == ST_CLEAR))
    else $error("dictionary write outside insert or sweep");

  // a closing code leaves no match open
  assert property (@(posedge clk) disable iff (rst)
    (push && push_end) |=> (!match_active && next_free_code == lzwc_pkg::FIRST_CODE))
    else $error("chunk state not cleared after closing code");

  // the queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    push |-> (level < lzwc_pkg::level_t'(lzwc_pkg::OUT_DEPTH) || codes.ready))
    else $error("result queue overflow");

  // live slots always carry a nonzero epoch
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLEAR) |-> (epoch != '0))
    else $error("zero epoch outside the clearing sweep");

endmodule

`default_nettype wire
